>>> hw/rtl/tlfr_pkg.sv
// Shared types for the type-length frame reassembler.
`timescale 1ns / 1ps
`default_nettype none
package tlfr_pkg;

  localparam int unsigned HDR_BYTES = 2;

  typedef struct packed {
    logic       done;
    logic [7:0] ftype;
    logic [7:0] plen;
  } frame_evt_t;

endpackage
`default_nettype wire

>>> hw/rtl/tlfr_store.sv
// Frame byte store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tlfr_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tlfr_parser.sv
// Feed and header tracking; writes incoming bytes into the store.
`timescale 1ns / 1ps
`default_nettype none
module tlfr_parser #(
  parameter int unsigned MAX_FRAME = 64,
  parameter int unsigned BUF_LIMIT = 128,
  parameter int unsigned AW        = 6,
  parameter int unsigned HW        = 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [7:0]          data_byte,
  input  wire logic                feed_start,
  input  wire logic [15:0]         feed_length,
  output logic                     wr_en,
  output logic      [AW-1:0]       wr_addr,
  output logic      [7:0]          wr_data,
  output tlfr_pkg::frame_evt_t     evt
);

  localparam logic [16:0] BUF17 = 17'(BUF_LIMIT);
  localparam logic [9:0]  MAX10 = 10'(MAX_FRAME);
  localparam logic [9:0]  HDR10 = 10'(tlfr_pkg::HDR_BYTES);

  logic [HW-1:0] held_r, held_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic          disc_r, disc_nxt;
  logic          done_r, done_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    plen_r, plen_nxt;

  logic [15:0]   flen_eff;
  logic [16:0]   sum17;
  logic          live;
  logic [15:0]   rem_base;
  logic          disc_base;
  logic [HW-1:0] held_base;
  logic [HW-1:0] held_inc;
  logic [7:0]    byte_len;
  logic [9:0]    need;

  always_comb begin
    held_nxt  = held_r;
    rem_nxt   = rem_r;
    disc_nxt  = disc_r;
    done_nxt  = 1'b0;
    type_nxt  = type_r;
    plen_nxt  = plen_r;
    wr_en     = 1'b0;
    flen_eff  = (feed_length == 16'd0) ? 16'd1 : feed_length;
    sum17     = 17'(held_r) + {1'b0, flen_eff};
    live      = feed_start || (rem_r != 16'd0);
    if (feed_start) begin
      rem_base  = flen_eff;
      disc_base = {1'b0, flen_eff} > BUF17;
      held_base = (!disc_base && (sum17 > BUF17)) ? '0 : held_r;
    end else begin
      rem_base  = rem_r;
      disc_base = disc_r;
      held_base = held_r;
    end
    held_inc = held_base + HW'(1);
    byte_len = (held_base == HW'(1)) ? data_byte : plen_r;
    need     = {2'b00, byte_len} + HDR10;
    wr_addr  = held_base[AW-1:0];
    wr_data  = data_byte;
    if (acc && live) begin
      rem_nxt  = rem_base - 16'd1;
      disc_nxt = disc_base;
      held_nxt = held_base;
      if (!disc_base) begin
        wr_en    = 1'b1;
        held_nxt = held_inc;
        if (held_base == '0) begin
          type_nxt = data_byte;
        end
        if (held_base == HW'(1)) begin
          plen_nxt = data_byte;
        end
        if (10'(held_inc) >= HDR10) begin
          if (need > MAX10) begin
            held_nxt = '0;
            disc_nxt = 1'b1;
          end else if (10'(held_inc) == need) begin
            held_nxt = '0;
            done_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      rem_r  <= '0;
      disc_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      rem_r  <= rem_nxt;
      disc_r <= disc_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    plen_r <= plen_nxt;
  end

  assign evt.done  = done_r;
  assign evt.ftype = type_r;
  assign evt.plen  = plen_r;

endmodule
`default_nettype wire

>>> hw/rtl/tlfr_readout.sv
// Read-out sequencer: walks the payload in the store into the output register.
`timescale 1ns / 1ps
`default_nettype none
module tlfr_readout #(
  parameter int unsigned AW = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tlfr_pkg::frame_evt_t evt,
  output logic                      rd_en,
  output logic      [AW-1:0]        rd_addr,
  input  wire logic [7:0]           rd_data,
  output logic                      busy,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [7:0]           out_frame_type,
  output logic      [7:0]           out_payload_byte,
  output logic      [5:0]           out_payload_index,
  output logic      [5:0]           out_payload_length,
  output logic                      out_has_payload,
  output logic                      out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_READ
  } state_t;

  state_t     state_r;
  logic [7:0] type_r;
  logic [7:0] plen_r;
  logic [7:0] iss_r;
  logic [7:0] pend_k_r;
  logic       rd_pend_r;
  logic       out_valid_r;
  logic [7:0] out_type_r;
  logic [7:0] out_byte_r;
  logic [5:0] out_idx_r;
  logic [5:0] out_len_r;
  logic       out_has_r;
  logic       out_last_r;

  logic       out_free;
  logic [8:0] addr_sum;

  assign out_free = !out_valid_r || !out_stall;
  assign addr_sum = {1'b0, iss_r} + 9'(tlfr_pkg::HDR_BYTES);
  assign rd_addr  = addr_sum[AW-1:0];
  assign rd_en    = (state_r == ST_READ) && !rd_pend_r && out_free;
  assign busy     = (state_r != ST_IDLE) || rd_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
    end else begin
      rd_pend_r <= rd_en;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
        out_type_r  <= type_r;
        out_byte_r  <= rd_data;
        out_idx_r   <= pend_k_r[5:0];
        out_len_r   <= plen_r[5:0];
        out_has_r   <= 1'b1;
        out_last_r  <= (pend_k_r == plen_r - 8'd1);
      end else if (state_r == ST_EMPTY && out_free) begin
        out_valid_r <= 1'b1;
        out_type_r  <= type_r;
        out_byte_r  <= '0;
        out_idx_r   <= '0;
        out_len_r   <= '0;
        out_has_r   <= 1'b0;
        out_last_r  <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (evt.done) begin
            type_r  <= evt.ftype;
            plen_r  <= evt.plen;
            iss_r   <= '0;
            state_r <= (evt.plen == 8'd0) ? ST_EMPTY : ST_READ;
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (rd_en) begin
            pend_k_r <= iss_r;
            iss_r    <= iss_r + 8'd1;
            if (iss_r == plen_r - 8'd1) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_type     = out_type_r;
  assign out_payload_byte   = out_byte_r;
  assign out_payload_index  = out_idx_r;
  assign out_payload_length = out_len_r;
  assign out_has_payload    = out_has_r;
  assign out_last           = out_last_r;

`ifndef SYNTH
  a_read_loads: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> out_valid_r)
    else $error("read data not loaded into output register");
  a_read_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (plen_r != 8'd0 && iss_r < plen_r))
    else $error("read-out counter out of range");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !rd_pend_r && (!out_valid_r || !out_stall))
    else $error("read issued while output register cannot take it");
  a_empty_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMPTY) |-> !rd_pend_r)
    else $error("read in flight during empty-frame result");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/type_length_frame_reassembler_core.sv
// First result of a frame: done, state, read-pending, output registers (empty frame: no read).
// Throughput: one input byte per cycle while no frame is pending or being read out.
// Read-out: one payload read in flight at a time, paced by the store's registered read port;
// input is stalled until the last read of the frame has returned.
// Reset: synchronous, active low; control state cleared, frame store contents undefined.
// Top level: type-length frame reassembler.
`timescale 1ns / 1ps
`default_nettype none
module type_length_frame_reassembler_core #(
  parameter int unsigned MAX_FRAME = 64,
  parameter int unsigned BUF_LIMIT = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_feed_start,
  input  wire logic [15:0] in_feed_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_frame_type,
  output logic      [7:0]  out_payload_byte,
  output logic      [5:0]  out_payload_index,
  output logic      [5:0]  out_payload_length,
  output logic             out_has_payload,
  output logic             out_last
);

  localparam int unsigned AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int unsigned HW = $clog2(MAX_FRAME + 1);

  logic                 acc;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [7:0]           wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [7:0]           rd_data;
  logic                 ro_busy;
  tlfr_pkg::frame_evt_t evt;

  assign in_stall = ro_busy || evt.done;
  assign acc      = in_valid && !in_stall;

  tlfr_parser #(
    .MAX_FRAME (MAX_FRAME),
    .BUF_LIMIT (BUF_LIMIT),
    .AW        (AW),
    .HW        (HW)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .data_byte   (in_data_byte),
    .feed_start  (in_feed_start),
    .feed_length (in_feed_length),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .evt         (evt)
  );

  tlfr_store #(
    .DEPTH (MAX_FRAME),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tlfr_readout #(
    .AW (AW)
  ) u_readout (
    .clk                (clk),
    .rst_n              (rst_n),
    .evt                (evt),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data),
    .busy               (ro_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_type     (out_frame_type),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_payload_length (out_payload_length),
    .out_has_payload    (out_has_payload),
    .out_last           (out_last)
  );

endmodule
`default_nettype wire
